@@ rtl/core/hpsf_pkg.sv @@
// ----------------------------------------------------------------------------
// hpsf_pkg: shared types and constants of the heap page store
// Field widths, operation codes, defaults and the memory command struct.
// ----------------------------------------------------------------------------
package hpsf_pkg;

    localparam int DEF_MAX_PAGES = 16;
    localparam int DEF_MAX_SLOTS = 64;

    localparam int SIZE_W  = 13;
    localparam int VALUE_W = 32;
    localparam int COST_W  = SIZE_W + 1;

    localparam logic [SIZE_W-1:0] HEADER_BYTES    = 13'd16;
    localparam logic [COST_W-1:0] SLOT_OVERHEAD   = 14'd4;
    localparam logic [SIZE_W-1:0] PAGE_SIZE_RESET = 13'd1024;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    // read and write strobes of one memory port
    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

endpackage

@@ rtl/core/hpsf_page_table.sv @@
// ----------------------------------------------------------------------------
// hpsf_page_table: per-page free bytes and record counts
// Single port synchronous memory, read data registered.
// ----------------------------------------------------------------------------
module hpsf_page_table #(
    parameter int MAX_PAGES = hpsf_pkg::DEF_MAX_PAGES,
    parameter int MAX_SLOTS = hpsf_pkg::DEF_MAX_SLOTS,
    localparam int PG_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
    localparam int RC_W = $clog2(MAX_SLOTS + 1)
) (
    input  logic                        clk,
    input  hpsf_pkg::mem_cmd_t          cmd,
    input  logic [PG_W-1:0]             addr,
    input  logic [hpsf_pkg::SIZE_W-1:0] wr_free,
    input  logic [RC_W-1:0]             wr_rec,
    output logic [hpsf_pkg::SIZE_W-1:0] rd_free,
    output logic [RC_W-1:0]             rd_rec
);
    import hpsf_pkg::*;

    logic [SIZE_W-1:0] free_mem [MAX_PAGES];
    logic [RC_W-1:0]   rec_mem  [MAX_PAGES];

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            free_mem[addr] <= wr_free;
            rec_mem[addr]  <= wr_rec;
        end
        // read data holds between reads
        if (cmd.rd)
        begin
            rd_free <= free_mem[addr];
            rd_rec  <= rec_mem[addr];
        end
    end

endmodule

@@ rtl/core/hpsf_value_store.sv @@
// ----------------------------------------------------------------------------
// hpsf_value_store: stored record values, page-major slot order
// Single port synchronous memory, read data registered.
// ----------------------------------------------------------------------------
module hpsf_value_store #(
    parameter int MAX_PAGES = hpsf_pkg::DEF_MAX_PAGES,
    parameter int MAX_SLOTS = hpsf_pkg::DEF_MAX_SLOTS,
    localparam int DEPTH = MAX_PAGES * MAX_SLOTS,
    localparam int VA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  hpsf_pkg::mem_cmd_t           cmd,
    input  logic [VA_W-1:0]              addr,
    input  logic [hpsf_pkg::VALUE_W-1:0] wdata,
    output logic [hpsf_pkg::VALUE_W-1:0] rdata
);
    import hpsf_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

@@ rtl/core/heap_page_store_first_fit_top.sv @@
// Steps: insert reads and checks each used page in turn, then takes a fresh page when none
//   fits or rejects when the table is full; status reads and reports each page in turn, or
//   reports once when no page is used; search reads each page's record count, then each
//   stored record, until the first match.
// Throughput: one item at a time, the next is taken in the idle cycle after the last result.
// Reset: control and page count clear and page size returns to its default at once; the memories are not cleared.
// ----------------------------------------------------------------------------
// heap_page_store_first_fit_top: first-fit heap page store
// Sequencer over a page table memory and a value store memory with a
// registered result output.
// ----------------------------------------------------------------------------
module heap_page_store_first_fit_top #(
    parameter int MAX_PAGES = hpsf_pkg::DEF_MAX_PAGES,
    parameter int MAX_SLOTS = hpsf_pkg::DEF_MAX_SLOTS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [hpsf_pkg::SIZE_W-1:0]  cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   kind,
    input  logic [hpsf_pkg::SIZE_W-1:0]  record_size,
    input  logic signed [hpsf_pkg::VALUE_W-1:0] value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [3:0]                   page_number,
    output logic [5:0]                   slot_number,
    output logic                         found,
    output logic                         rejected,
    output logic [6:0]                   record_count,
    output logic [4:0]                   page_count,
    output logic                         last
);
    import hpsf_pkg::*;

    localparam int DEPTH = MAX_PAGES * MAX_SLOTS;
    localparam int VA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PG_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PC_W  = $clog2(MAX_PAGES + 1);
    localparam int SL_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int RC_W  = $clog2(MAX_SLOTS + 1);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_INS_RD    = 9'b000000010,
        ST_INS_CHK   = 9'b000000100,
        ST_INS_NEW   = 9'b000001000,
        ST_STAT_RD   = 9'b000010000,
        ST_STAT_OUT  = 9'b000100000,
        ST_SRCH_PG   = 9'b001000000,
        ST_SRCH_SCAN = 9'b010000000,
        ST_EMIT      = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [SIZE_W-1:0]  page_size_reg;
    logic [PC_W-1:0]    pages_used_reg, pages_used_next;
    logic [PC_W-1:0]    p_reg, p_next;
    logic [RC_W-1:0]    s_reg, s_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [SL_W-1:0]    cmp_slot_reg, cmp_slot_next;
    logic               found_reg, found_next;
    logic [PG_W-1:0]    hit_page_reg, hit_page_next;
    logic [SL_W-1:0]    hit_slot_reg, hit_slot_next;
    logic [COST_W-1:0]  cost_reg, cost_next;
    logic [VALUE_W-1:0] value_reg, value_next;

    // page table and value store ports
    mem_cmd_t           pt_cmd, vs_cmd;
    logic [PG_W-1:0]    pt_addr;
    logic [SIZE_W-1:0]  pt_wr_free, pt_rd_free;
    logic [RC_W-1:0]    pt_wr_rec, pt_rd_rec;
    logic [VA_W-1:0]    vs_addr;
    logic [VALUE_W-1:0] vs_rdata;

    // output register
    logic               out_valid_reg;
    logic               out_load, out_free;
    logic [3:0]         res_page, page_number_reg;
    logic [5:0]         res_slot, slot_number_reg;
    logic               res_found, found_out_reg;
    logic               res_rejected, rejected_reg;
    logic [6:0]         res_count, record_count_reg;
    logic [4:0]         res_pages, page_count_reg;
    logic               res_last, last_reg;

    logic [SIZE_W-1:0]  fresh_free;
    logic               fits;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    assign fresh_free = (page_size_reg >= HEADER_BYTES) ? page_size_reg - HEADER_BYTES
                                                        : '0;
    assign fits = ({1'b0, pt_rd_free} >= cost_reg) && (pt_rd_rec < RC_W'(MAX_SLOTS));

    hpsf_page_table #(
        .MAX_PAGES (MAX_PAGES),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_page_table (
        .clk     (clk),
        .cmd     (pt_cmd),
        .addr    (pt_addr),
        .wr_free (pt_wr_free),
        .wr_rec  (pt_wr_rec),
        .rd_free (pt_rd_free),
        .rd_rec  (pt_rd_rec)
    );

    hpsf_value_store #(
        .MAX_PAGES (MAX_PAGES),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_value_store (
        .clk   (clk),
        .cmd   (vs_cmd),
        .addr  (vs_addr),
        .wdata (value_reg),
        .rdata (vs_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        pages_used_next = pages_used_reg;
        p_next          = p_reg;
        s_next          = s_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_slot_next   = cmp_slot_reg;
        found_next      = found_reg;
        hit_page_next   = hit_page_reg;
        hit_slot_next   = hit_slot_reg;
        cost_next       = cost_reg;
        value_next      = value_reg;

        pt_cmd     = '0;
        pt_addr    = p_reg[PG_W-1:0];
        pt_wr_free = '0;
        pt_wr_rec  = '0;
        vs_cmd     = '0;
        vs_addr    = VA_W'(p_reg[PG_W-1:0]) * VA_W'(MAX_SLOTS) + VA_W'(s_reg[SL_W-1:0]);

        out_load     = 1'b0;
        res_page     = '0;
        res_slot     = '0;
        res_found    = 1'b0;
        res_rejected = 1'b0;
        res_count    = '0;
        res_pages    = '0;
        res_last     = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cost_next  = {1'b0, record_size} + SLOT_OVERHEAD;
                    value_next = value;
                    p_next     = '0;
                    unique case (kind)
                        KIND_INSERT:
                        begin
                            state_next = (pages_used_reg == '0) ? ST_INS_NEW : ST_INS_RD;
                        end
                        KIND_STATUS:
                        begin
                            if (pages_used_reg == '0)
                            begin
                                found_next    = 1'b0;
                                hit_page_next = '0;
                                hit_slot_next = '0;
                                state_next    = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_STAT_RD;
                            end
                        end
                        KIND_SEARCH:
                        begin
                            state_next = ST_SRCH_PG;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INS_RD:
            begin
                pt_cmd.rd  = 1'b1;
                state_next = ST_INS_CHK;
            end
            ST_INS_CHK:
            begin
                if (fits)
                begin
                    if (out_free)
                    begin
                        pt_cmd.wr  = 1'b1;
                        pt_wr_free = 13'({1'b0, pt_rd_free} - cost_reg);
                        pt_wr_rec  = pt_rd_rec + 1'b1;
                        vs_cmd.wr  = 1'b1;
                        vs_addr    = VA_W'(p_reg[PG_W-1:0]) * VA_W'(MAX_SLOTS)
                                   + VA_W'(pt_rd_rec[SL_W-1:0]);
                        out_load   = 1'b1;
                        res_page   = 4'(p_reg);
                        res_slot   = 6'(pt_rd_rec);
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = (p_reg + 1'b1 == pages_used_reg) ? ST_INS_NEW : ST_INS_RD;
                end
            end
            ST_INS_NEW:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (pages_used_reg >= PC_W'(MAX_PAGES))
                    begin
                        res_rejected = 1'b1;
                    end
                    else
                    begin
                        // fresh page, an oversized record leaves it at zero free
                        pt_cmd.wr  = 1'b1;
                        pt_addr    = pages_used_reg[PG_W-1:0];
                        pt_wr_free = ({1'b0, fresh_free} >= cost_reg)
                                   ? 13'({1'b0, fresh_free} - cost_reg) : '0;
                        pt_wr_rec  = RC_W'(1);
                        vs_cmd.wr  = 1'b1;
                        vs_addr    = VA_W'(pages_used_reg[PG_W-1:0]) * VA_W'(MAX_SLOTS);
                        res_page   = 4'(pages_used_reg);
                        pages_used_next = pages_used_reg + 1'b1;
                    end
                end
            end
            ST_STAT_RD:
            begin
                pt_cmd.rd  = 1'b1;
                state_next = ST_STAT_OUT;
            end
            ST_STAT_OUT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    res_page  = 4'(p_reg);
                    res_count = 7'(pt_rd_rec);
                    res_pages = 5'(pages_used_reg);
                    res_last  = (p_reg + 1'b1 == pages_used_reg);
                    p_next    = p_reg + 1'b1;
                    state_next = res_last ? ST_IDLE : ST_STAT_RD;
                end
            end
            ST_SRCH_PG:
            begin
                if (p_reg == pages_used_reg)
                begin
                    found_next    = 1'b0;
                    hit_page_next = '0;
                    hit_slot_next = '0;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    pt_cmd.rd      = 1'b1;
                    s_next         = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = ST_SRCH_SCAN;
                end
            end
            ST_SRCH_SCAN:
            begin
                // one slot read issued per cycle, compared the cycle after
                if (cmp_valid_reg && (vs_rdata == value_reg))
                begin
                    found_next     = 1'b1;
                    hit_page_next  = p_reg[PG_W-1:0];
                    hit_slot_next  = cmp_slot_reg;
                    cmp_valid_next = 1'b0;
                    state_next     = ST_EMIT;
                end
                else if (s_reg < pt_rd_rec)
                begin
                    vs_cmd.rd      = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_slot_next  = s_reg[SL_W-1:0];
                    s_next         = s_reg + 1'b1;
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                    p_next         = p_reg + 1'b1;
                    state_next     = ST_SRCH_PG;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    res_found  = found_reg;
                    res_page   = 4'(hit_page_reg);
                    res_slot   = 6'(hit_slot_reg);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            page_size_reg  <= PAGE_SIZE_RESET;
            pages_used_reg <= '0;
            p_reg          <= '0;
            s_reg          <= '0;
            cmp_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pages_used_reg <= pages_used_next;
            p_reg          <= p_next;
            s_reg          <= s_next;
            cmp_valid_reg  <= cmp_valid_next;
            found_reg      <= found_next;
            if (cfg_valid && cfg_ready)
            begin
                page_size_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_slot_reg <= cmp_slot_next;
        hit_page_reg <= hit_page_next;
        hit_slot_reg <= hit_slot_next;
        cost_reg     <= cost_next;
        value_reg    <= value_next;
        if (out_load)
        begin
            page_number_reg  <= res_page;
            slot_number_reg  <= res_slot;
            found_out_reg    <= res_found;
            rejected_reg     <= res_rejected;
            record_count_reg <= res_count;
            page_count_reg   <= res_pages;
            last_reg         <= res_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign page_number  = page_number_reg;
    assign slot_number  = slot_number_reg;
    assign found        = found_out_reg;
    assign rejected     = rejected_reg;
    assign record_count = record_count_reg;
    assign page_count   = page_count_reg;
    assign last         = last_reg;

    // page count stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        pages_used_reg <= PC_W'(MAX_PAGES))
        else $error("page count beyond table size");

    // pages are only added, one at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (pages_used_reg != $past(pages_used_reg)) |->
            (pages_used_reg == $past(pages_used_reg) + 1'b1))
        else $error("page count changed by other than one");

    // a rejected insert only when the table is full
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> (pages_used_reg == PC_W'(MAX_PAGES)))
        else $error("insert rejected with free page entries");

    // value store written only while placing an insert
    assert property (@(posedge clk) disable iff (!rst_n)
        vs_cmd.wr |-> (out_load && ((state_reg == ST_INS_CHK) || (state_reg == ST_INS_NEW))))
        else $error("value store written outside insert");

endmodule
